>>> src/crc_pkg.sv
// Shared types and constants for the command retransmit controller.
// Holds the request and response payload structs, command codes and register indexes.
// No dependencies.
package crc_pkg;

   localparam int unsigned DEFAULT_QUEUE_SLOTS = 4;

   localparam int unsigned TIME_WIDTH    = 32;
   localparam int unsigned SEQ_WIDTH     = 8;
   localparam int unsigned CODE_WIDTH    = 2;
   localparam int unsigned TIMEOUT_WIDTH = 16;
   localparam int unsigned RETRY_WIDTH   = 4;
   localparam int unsigned CSR_IDX_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH = 16;

   // Operation codes carried by a request transfer.
   localparam logic OP_REQUEST = 1'b0;
   localparam logic OP_SERVICE = 1'b1;

   // Command codes; the fourth code is unused and a request carrying it is ignored.
   localparam logic [CODE_WIDTH-1:0] COMMAND_MANUAL = 2'd0;
   localparam logic [CODE_WIDTH-1:0] COMMAND_AUTO   = 2'd1;
   localparam logic [CODE_WIDTH-1:0] COMMAND_SLEEP  = 2'd2;
   localparam logic [CODE_WIDTH-1:0] COMMAND_UNUSED = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ACK_TIMEOUT = 4'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAX_RETRIES = 4'd1;

   localparam logic [TIMEOUT_WIDTH-1:0] ACK_TIMEOUT_RESET = 16'd1200;
   localparam logic [RETRY_WIDTH-1:0]   MAX_RETRIES_RESET = 4'd3;

   typedef struct packed {
      logic                  operation;
      logic [CODE_WIDTH-1:0] command_code;
      logic [TIME_WIDTH-1:0] now_ms;
      logic                  packet_present;
      logic                  ack_present;
      logic [SEQ_WIDTH-1:0]  ack_sequence;
      logic                  manual_known;
      logic                  node_reports_manual;
   } req_type;

   typedef struct packed {
      logic                  transmit;
      logic [CODE_WIDTH-1:0] tx_command;
      logic [SEQ_WIDTH-1:0]  tx_sequence;
      logic                  is_retry;
      logic                  gave_up;
      logic                  confirmed;
      logic [SEQ_WIDTH-1:0]  closed_sequence;
      logic                  awaiting_ack;
      logic                  command_dropped;
      logic [1:0]            queued_count;
   } rsp_type;

endpackage

>>> src/crc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the command queue storage; no dependencies.
module crc_ram #(
   parameter int unsigned WIDTH = 2,
   parameter int unsigned DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/command_retransmit_controller_top.sv
// Command retransmit controller: a request goes through the input register, then the
// result register; throughput is one item per cycle unless the result side stalls.
// The queue head comes from a registered-read RAM, addressed by the next read pointer.
// Reset is synchronous and active high; it clears control state and the pointers,
// and loads the configuration defaults. Queue storage is not cleared.
// Depends on crc_pkg and crc_ram.
module command_retransmit_controller_top #(
   parameter int unsigned QUEUE_SLOTS = crc_pkg::DEFAULT_QUEUE_SLOTS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  crc_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output crc_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [crc_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [crc_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   localparam int unsigned PTR_W = $clog2(QUEUE_SLOTS);
   localparam int unsigned CNT_W = PTR_W + 1;
   localparam int unsigned CW    = crc_pkg::CODE_WIDTH;
   localparam int unsigned SW    = crc_pkg::SEQ_WIDTH;
   localparam int unsigned TW    = crc_pkg::TIME_WIDTH;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] result;
      if (ptr == PTR_W'(QUEUE_SLOTS - 1)) begin
         result = '0;
      end else begin
         result = ptr + PTR_W'(1);
      end
      return result;
   endfunction

   function automatic logic [CNT_W-1:0] ptr_count(input logic [PTR_W-1:0] wp,
                                                  input logic [PTR_W-1:0] rp);
      logic [CNT_W-1:0] result;
      if (wp >= rp) begin
         result = {1'b0, wp} - {1'b0, rp};
      end else begin
         result = {1'b0, wp} + CNT_W'(QUEUE_SLOTS) - {1'b0, rp};
      end
      return result;
   endfunction

   // Configuration registers.
   logic [crc_pkg::TIMEOUT_WIDTH-1:0] timeout_ff;
   logic [crc_pkg::RETRY_WIDTH-1:0]   max_retries_ff;

   // Handshake and payload registers.
   logic             in_valid_ff, in_valid_in;
   crc_pkg::req_type in_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   crc_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             accept;
   logic             advance;

   // Controller state.
   logic [PTR_W-1:0]                wp_ff, wp_in;
   logic [PTR_W-1:0]                rp_ff, rp_in;
   logic [CW-1:0]                   pend_cmd_ff, pend_cmd_in;
   logic [SW-1:0]                   pend_seq_ff, pend_seq_in;
   logic                            pend_valid_ff, pend_valid_in;
   logic [crc_pkg::RETRY_WIDTH-1:0] retries_ff, retries_in;
   logic [TW-1:0]                   deadline_ff, deadline_in;
   logic [SW-1:0]                   last_seq_ff, last_seq_in;
   logic                            expects_manual_ff, expects_manual_in;
   logic                            observable_ff, observable_in;
   logic                            manual_seen_ff, manual_seen_in;

   // Queue storage and head bypass.
   logic          q_wr_en;
   logic [CW-1:0] q_rd_data;
   logic          byp_ff, byp_in;
   logic [CW-1:0] byp_data_ff;
   logic [CW-1:0] head_cmd;

   // Datapath intermediates.
   logic          is_service;
   logic          code_ok;
   logic          q_full;
   logic [TW-1:0] elapsed;
   logic          expired;
   logic [TW-1:0] new_deadline;
   logic [SW-1:0] seq_inc;
   logic          sent;
   logic          pend_valid_mid;
   logic          ack_ok;
   logic [CNT_W-1:0] count_next;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff     <= crc_pkg::ACK_TIMEOUT_RESET;
         max_retries_ff <= crc_pkg::MAX_RETRIES_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            crc_pkg::CSR_ACK_TIMEOUT: timeout_ff <= csr_wdata[crc_pkg::TIMEOUT_WIDTH-1:0];
            crc_pkg::CSR_MAX_RETRIES: max_retries_ff <= csr_wdata[crc_pkg::RETRY_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // The item in the input register is processed when the result register is free
   // or is being emptied in this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   crc_ram #(
      .WIDTH(CW),
      .DEPTH(QUEUE_SLOTS)
   ) u_queue (
      .clock  (clock),
      .wr_en  (q_wr_en),
      .wr_addr(wp_ff),
      .wr_data(in_data_ff.command_code),
      .rd_addr(rp_in),
      .rd_data(q_rd_data)
   );

   // A write landing on the slot being read in the same cycle is forwarded.
   assign byp_in   = q_wr_en && (wp_ff == rp_in);
   assign head_cmd = byp_ff ? byp_data_ff : q_rd_data;

   always_comb begin
      is_service   = (in_data_ff.operation == crc_pkg::OP_SERVICE);
      code_ok      = (in_data_ff.command_code != crc_pkg::COMMAND_UNUSED);
      q_full       = (ptr_next(wp_ff) == rp_ff);
      elapsed      = in_data_ff.now_ms - deadline_ff;
      expired      = !elapsed[TW-1];
      new_deadline = in_data_ff.now_ms + TW'(timeout_ff);
      seq_inc      = last_seq_ff + SW'(1);
      if (seq_inc == '0) begin
         seq_inc = SW'(1);
      end

      wp_in             = wp_ff;
      rp_in             = rp_ff;
      pend_cmd_in       = pend_cmd_ff;
      pend_seq_in       = pend_seq_ff;
      pend_valid_in     = pend_valid_ff;
      retries_in        = retries_ff;
      deadline_in       = deadline_ff;
      last_seq_in       = last_seq_ff;
      expects_manual_in = expects_manual_ff;
      observable_in     = observable_ff;
      manual_seen_in    = manual_seen_ff;
      q_wr_en           = 1'b0;
      sent              = 1'b0;
      pend_valid_mid    = pend_valid_ff;
      ack_ok            = 1'b0;
      rsp_data_in       = '0;

      if (advance && !is_service) begin
         if (code_ok) begin
            if (q_full) begin
               rsp_data_in.command_dropped = 1'b1;
            end else begin
               q_wr_en = 1'b1;
               wp_in   = ptr_next(wp_ff);
            end
         end
      end else if (advance) begin
         if (pend_valid_ff) begin
            if (expired) begin
               if (retries_ff != '0) begin
                  retries_in              = retries_ff - 1'b1;
                  deadline_in             = new_deadline;
                  sent                    = 1'b1;
                  rsp_data_in.transmit    = 1'b1;
                  rsp_data_in.is_retry    = 1'b1;
                  rsp_data_in.tx_command  = pend_cmd_ff;
                  rsp_data_in.tx_sequence = pend_seq_ff;
               end else begin
                  rsp_data_in.gave_up         = 1'b1;
                  rsp_data_in.closed_sequence = pend_seq_ff;
                  pend_valid_mid              = 1'b0;
               end
            end
         end else if (wp_ff != rp_ff) begin
            rp_in             = ptr_next(rp_ff);
            last_seq_in       = seq_inc;
            pend_cmd_in       = head_cmd;
            pend_seq_in       = seq_inc;
            pend_valid_mid    = 1'b1;
            expects_manual_in = (head_cmd == crc_pkg::COMMAND_MANUAL);
            observable_in     = (head_cmd != crc_pkg::COMMAND_SLEEP);
            retries_in        = (head_cmd == crc_pkg::COMMAND_SLEEP) ? '0 : max_retries_ff;
            deadline_in       = new_deadline;
            sent              = 1'b1;
            rsp_data_in.transmit    = 1'b1;
            rsp_data_in.tx_command  = head_cmd;
            rsp_data_in.tx_sequence = seq_inc;
         end

         pend_valid_in = pend_valid_mid;
         // Without a transmit, a packet may confirm by echoed sequence, or else by the
         // node's most recently reported manual state.
         if (!sent && in_data_ff.packet_present) begin
            if (in_data_ff.manual_known) begin
               manual_seen_in = in_data_ff.node_reports_manual;
            end
            if (in_data_ff.ack_present) begin
               ack_ok = pend_valid_mid && (in_data_ff.ack_sequence == pend_seq_ff);
            end else begin
               ack_ok = pend_valid_mid && observable_ff &&
                        (manual_seen_in == expects_manual_ff);
            end
            if (ack_ok) begin
               rsp_data_in.confirmed       = 1'b1;
               rsp_data_in.closed_sequence = pend_seq_ff;
               pend_valid_in               = 1'b0;
            end
         end
      end

      count_next               = ptr_count(wp_in, rp_in);
      rsp_data_in.awaiting_ack = pend_valid_in;
      rsp_data_in.queued_count = count_next[1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         wp_ff             <= '0;
         rp_ff             <= '0;
         pend_cmd_ff       <= '0;
         pend_seq_ff       <= '0;
         pend_valid_ff     <= 1'b0;
         retries_ff        <= '0;
         deadline_ff       <= '0;
         last_seq_ff       <= '0;
         expects_manual_ff <= 1'b0;
         observable_ff     <= 1'b0;
         manual_seen_ff    <= 1'b0;
         byp_ff            <= 1'b0;
      end else begin
         in_valid_ff       <= in_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         wp_ff             <= wp_in;
         rp_ff             <= rp_in;
         pend_cmd_ff       <= pend_cmd_in;
         pend_seq_ff       <= pend_seq_in;
         pend_valid_ff     <= pend_valid_in;
         retries_ff        <= retries_in;
         deadline_ff       <= deadline_in;
         last_seq_ff       <= last_seq_in;
         expects_manual_ff <= expects_manual_in;
         observable_ff     <= observable_in;
         manual_seen_ff    <= manual_seen_in;
         byp_ff            <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
      byp_data_ff <= in_data_ff.command_code;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // A transfer that sends a frame never also closes a sequence.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.transmit |->
         !rsp_data_ff.confirmed && !rsp_data_ff.gave_up && rsp_data_ff.awaiting_ack)
      else $error("transmit result also closes a sequence");

   // Sequence zero is never used, so a closed sequence is always nonzero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.confirmed || rsp_data_ff.gave_up) |->
         rsp_data_ff.closed_sequence != '0)
      else $error("closed sequence is zero");

   // The ring never holds more than QUEUE_SLOTS-1 commands.
   assert property (@(posedge clock) disable iff (reset)
      ptr_count(wp_ff, rp_ff) < CNT_W'(QUEUE_SLOTS))
      else $error("queue occupancy out of range");

   // An in-flight command always carries a nonzero sequence.
   assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> pend_seq_ff != '0 && last_seq_ff != '0)
      else $error("in-flight command without a sequence");
`endif

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for command_retransmit_controller_top.
// Runs a table of directed transfers and then random traffic in several configuration
// phases. Each result is checked against a built-in model, or against a typed-in
// expectation given by a directed row. Depends on crc_pkg and the controller RTL.
module tb_top;

   localparam int unsigned SLOTS           = crc_pkg::DEFAULT_QUEUE_SLOTS;
   localparam int unsigned CW              = crc_pkg::CODE_WIDTH;
   localparam int unsigned SW              = crc_pkg::SEQ_WIDTH;
   localparam int unsigned TW              = crc_pkg::TIME_WIDTH;
   localparam int unsigned DW              = crc_pkg::CSR_DATA_WIDTH;
   localparam int unsigned NUM_PHASES      = 5;
   localparam int unsigned ITEMS_PER_PHASE = 350;
   localparam int unsigned HOLD_OFF_CYCLES = 60;
   localparam int unsigned SETTLE_CYCLES   = 6;
   localparam int unsigned WATCHDOG_LIMIT  = 3000;
   localparam int unsigned MAX_REPORTS     = 50;

   typedef struct {
      crc_pkg::req_type item;
      bit               has_lit;
      crc_pkg::rsp_type lit;
   } directed_row_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   crc_pkg::req_type                   req_data = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   crc_pkg::rsp_type                   rsp_data;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [crc_pkg::CSR_IDX_WIDTH-1:0]  csr_index = '0;
   logic [crc_pkg::CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   // A typed-in expectation travels beside the request payload.
   bit                                 req_lit_on = 1'b0;
   crc_pkg::rsp_type                   req_lit = '0;

   // Controller model state.
   logic [CW-1:0]                      slot_mem [SLOTS];
   int unsigned                        wr_ptr = 0;
   int unsigned                        rd_ptr = 0;
   logic [CW-1:0]                      inflight_cmd = '0;
   logic [SW-1:0]                      inflight_seq = '0;
   bit                                 inflight = 1'b0;
   logic [crc_pkg::RETRY_WIDTH-1:0]    retries_left = '0;
   logic [TW-1:0]                      retry_at = '0;
   logic [SW-1:0]                      seq_counter = '0;
   bit                                 want_manual = 1'b0;
   bit                                 observable = 1'b0;
   bit                                 manual_seen = 1'b0;
   logic [crc_pkg::TIMEOUT_WIDTH-1:0]  timeout_cfg = crc_pkg::ACK_TIMEOUT_RESET;
   logic [crc_pkg::RETRY_WIDTH-1:0]    retries_cfg = crc_pkg::MAX_RETRIES_RESET;

   crc_pkg::rsp_type                   expected_q [$];
   int unsigned                        mismatch_count = 0;
   int unsigned                        quiet_cycles = 0;
   logic [TW-1:0]                      clock_ms = '0;
   bit                                 idle_on = 1'b1;
   bit                                 hold_off_req = 1'b0;

   command_retransmit_controller_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned next_slot(int unsigned p);
      return (p + 1) % SLOTS;
   endfunction

   function automatic int unsigned gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
   endfunction

   // Applies one transfer to the model and returns the result it must produce.
   function automatic crc_pkg::rsp_type advance_controller(crc_pkg::req_type r);
      crc_pkg::rsp_type o;
      logic [CW-1:0]    head;
      logic [TW-1:0]    elapsed;
      bit               sent;
      bit               ok;
      o = '0;
      sent = 1'b0;
      ok = 1'b0;
      if (r.operation == crc_pkg::OP_REQUEST) begin
         if (r.command_code != crc_pkg::COMMAND_UNUSED) begin
            if (next_slot(wr_ptr) == rd_ptr) begin
               o.command_dropped = 1'b1;
            end else begin
               slot_mem[wr_ptr] = r.command_code;
               wr_ptr = next_slot(wr_ptr);
            end
         end
      end else begin
         if (inflight) begin
            // The deadline has passed when the wrapped difference is not negative.
            elapsed = r.now_ms - retry_at;
            if (!elapsed[TW-1]) begin
               if (retries_left != 0) begin
                  retries_left = retries_left - 1'b1;
                  retry_at = r.now_ms + TW'(timeout_cfg);
                  o.transmit = 1'b1;
                  o.is_retry = 1'b1;
                  o.tx_command = inflight_cmd;
                  o.tx_sequence = inflight_seq;
                  sent = 1'b1;
               end else begin
                  o.gave_up = 1'b1;
                  o.closed_sequence = inflight_seq;
                  inflight = 1'b0;
               end
            end
         end else if (wr_ptr != rd_ptr) begin
            head = slot_mem[rd_ptr];
            rd_ptr = next_slot(rd_ptr);
            // Sequence numbers skip zero when they wrap.
            seq_counter = (seq_counter == 8'hFF) ? 8'd1 : seq_counter + 8'd1;
            inflight_cmd = head;
            inflight_seq = seq_counter;
            inflight = 1'b1;
            want_manual = (head == crc_pkg::COMMAND_MANUAL);
            observable = (head != crc_pkg::COMMAND_SLEEP);
            retries_left = (head == crc_pkg::COMMAND_SLEEP) ? '0 : retries_cfg;
            retry_at = r.now_ms + TW'(timeout_cfg);
            o.transmit = 1'b1;
            o.tx_command = head;
            o.tx_sequence = seq_counter;
            sent = 1'b1;
         end
         if (!sent && r.packet_present) begin
            if (r.manual_known) manual_seen = r.node_reports_manual;
            if (r.ack_present) ok = inflight && (r.ack_sequence == inflight_seq);
            else if (inflight && observable) ok = (manual_seen == want_manual);
            if (ok) begin
               o.confirmed = 1'b1;
               o.closed_sequence = inflight_seq;
               inflight = 1'b0;
            end
         end
      end
      o.awaiting_ack = inflight;
      o.queued_count = 2'((wr_ptr + SLOTS - rd_ptr) % SLOTS);
      return o;
   endfunction

   // Mostly well-formed traffic: acks usually echo the sequence in flight and
   // time mostly advances in steps that reach deadlines now and then.
   function automatic crc_pkg::req_type random_item();
      crc_pkg::req_type r;
      r.operation = crc_pkg::OP_SERVICE;
      r.command_code = CW'($urandom);
      r.now_ms = $urandom;
      r.packet_present = 1'($urandom_range(0, 1));
      r.ack_present = 1'($urandom_range(0, 1));
      r.ack_sequence = ($urandom_range(0, 9) < 6) ? inflight_seq : SW'($urandom);
      r.manual_known = 1'($urandom_range(0, 1));
      r.node_reports_manual = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 35) begin
         r.operation = crc_pkg::OP_REQUEST;
         r.command_code = ($urandom_range(0, 9) == 0) ? crc_pkg::COMMAND_UNUSED :
                                                        CW'($urandom_range(0, 2));
      end else begin
         case ($urandom_range(0, 19))
            0:       clock_ms = $urandom;
            1, 2, 3: clock_ms = clock_ms + TW'(timeout_cfg) + $urandom_range(0, 3);
            4, 5:    clock_ms = retry_at - 1 + $urandom_range(0, 2);
            default: clock_ms = clock_ms + $urandom_range(0, timeout_cfg / 2 + 1);
         endcase
         r.now_ms = clock_ms;
      end
      return r;
   endfunction

   function automatic crc_pkg::req_type request_of(logic [CW-1:0] code);
      crc_pkg::req_type r;
      r = '0;
      r.operation = crc_pkg::OP_REQUEST;
      r.command_code = code;
      return r;
   endfunction

   function automatic crc_pkg::req_type service_pass(int unsigned now, int unsigned pkt,
                                                     int unsigned ackp, int unsigned ack,
                                                     int unsigned known, int unsigned manual);
      crc_pkg::req_type r;
      r = '0;
      r.operation = crc_pkg::OP_SERVICE;
      r.now_ms = TW'(now);
      r.packet_present = 1'(pkt);
      r.ack_present = 1'(ackp);
      r.ack_sequence = SW'(ack);
      r.manual_known = 1'(known);
      r.node_reports_manual = 1'(manual);
      return r;
   endfunction

   function automatic crc_pkg::rsp_type rsp_of(int unsigned tx, int unsigned cmd,
                                               int unsigned seq, int unsigned retry,
                                               int unsigned gave, int unsigned conf,
                                               int unsigned closed, int unsigned busy,
                                               int unsigned drop, int unsigned count);
      crc_pkg::rsp_type o;
      o.transmit = 1'(tx);
      o.tx_command = CW'(cmd);
      o.tx_sequence = SW'(seq);
      o.is_retry = 1'(retry);
      o.gave_up = 1'(gave);
      o.confirmed = 1'(conf);
      o.closed_sequence = SW'(closed);
      o.awaiting_ack = 1'(busy);
      o.command_dropped = 1'(drop);
      o.queued_count = 2'(count);
      return o;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
      end
   endtask

   task automatic check_result(input crc_pkg::rsp_type got);
      crc_pkg::rsp_type want;
      if (expected_q.size() == 0) begin
         report_mismatch("result transfer with no request outstanding");
         return;
      end
      want = expected_q.pop_front();
      compare_field("transmit", 32'(got.transmit), 32'(want.transmit));
      compare_field("tx_command", 32'(got.tx_command), 32'(want.tx_command));
      compare_field("tx_sequence", 32'(got.tx_sequence), 32'(want.tx_sequence));
      compare_field("is_retry", 32'(got.is_retry), 32'(want.is_retry));
      compare_field("gave_up", 32'(got.gave_up), 32'(want.gave_up));
      compare_field("confirmed", 32'(got.confirmed), 32'(want.confirmed));
      compare_field("closed_sequence", 32'(got.closed_sequence),
                    32'(want.closed_sequence));
      compare_field("awaiting_ack", 32'(got.awaiting_ack), 32'(want.awaiting_ack));
      compare_field("command_dropped", 32'(got.command_dropped),
                    32'(want.command_dropped));
      compare_field("queued_count", 32'(got.queued_count), 32'(want.queued_count));
   endtask

   always @(posedge clock) begin
      crc_pkg::rsp_type predicted;
      if (!reset) begin
         if (req_valid && req_stall === 1'b0) begin
            predicted = advance_controller(req_data);
            expected_q.push_back(req_lit_on ? req_lit : predicted);
         end
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) check_result(rsp_data);
      end
   end

   // Ends the run if no transfer of any kind completes for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall == 1'b0) || (csr_valid && csr_ready === 1'b1)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles++;
      end
   end

   // Result-side back-pressure, including one long hold-off when requested.
   initial begin : rsp_pacing
      @(negedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end else begin
            rsp_stall <= idle_on && ($urandom_range(0, 2) == 0);
            repeat (idle_on ? gap_len() : 1) @(negedge clock);
         end
      end
   end

   // The payload is chosen at the falling edge, after the model has taken
   // the previous transfer into account.
   task automatic send_item(input bit use_random, input crc_pkg::req_type row,
                            input bit lit_on, input crc_pkg::rsp_type lit);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= use_random ? random_item() : row;
      req_lit_on <= lit_on;
      req_lit <= lit;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic sender_gap();
      int unsigned n;
      if (!idle_on || $urandom_range(0, 3) != 0) return;
      n = gap_len();
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [crc_pkg::CSR_IDX_WIDTH-1:0] idx,
                                 input logic [crc_pkg::CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         crc_pkg::CSR_ACK_TIMEOUT: timeout_cfg = value[crc_pkg::TIMEOUT_WIDTH-1:0];
         crc_pkg::CSR_MAX_RETRIES: retries_cfg = value[crc_pkg::RETRY_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      directed_row_type rows [$];
      int unsigned      timeouts [NUM_PHASES];
      int unsigned      retries [NUM_PHASES];
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed part, run with the reset configuration.
      rows.push_back('{service_pass(0, 0, 0, 0, 0, 0), 1'b1, rsp_of(0,0,0,0,0,0,0,0,0,0)});
      rows.push_back('{request_of(crc_pkg::COMMAND_UNUSED), 1'b1,
                       rsp_of(0,0,0,0,0,0,0,0,0,0)});
      rows.push_back('{request_of(crc_pkg::COMMAND_MANUAL), 1'b1,
                       rsp_of(0,0,0,0,0,0,0,0,0,1)});
      rows.push_back('{request_of(crc_pkg::COMMAND_AUTO), 1'b1,
                       rsp_of(0,0,0,0,0,0,0,0,0,2)});
      rows.push_back('{request_of(crc_pkg::COMMAND_SLEEP), 1'b1,
                       rsp_of(0,0,0,0,0,0,0,0,0,3)});
      rows.push_back('{request_of(crc_pkg::COMMAND_MANUAL), 1'b1,
                       rsp_of(0,0,0,0,0,0,0,0,1,3)});
      rows.push_back('{service_pass(100, 0, 0, 0, 0, 0), 1'b1,
                       rsp_of(1,crc_pkg::COMMAND_MANUAL,1,0,0,0,0,1,0,2)});
      rows.push_back('{service_pass(1299, 1, 1, 255, 0, 0), 1'b0, '0});
      // The deadline itself counts as passed.
      rows.push_back('{service_pass(1300, 0, 0, 0, 0, 0), 1'b1,
                       rsp_of(1,crc_pkg::COMMAND_MANUAL,1,1,0,0,0,1,0,2)});
      rows.push_back('{service_pass(1400, 1, 0, 0, 1, 1), 1'b0, '0});
      rows.push_back('{service_pass(32'hFFFF_FF00, 0, 0, 0, 0, 0), 1'b1,
                       rsp_of(1,crc_pkg::COMMAND_AUTO,2,0,0,0,0,1,0,1)});
      // Deadline wrapped past zero; a stale manual report must not confirm auto.
      rows.push_back('{service_pass(32'hFFFF_FFFF, 1, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{service_pass(32'h0000_03B0, 0, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{service_pass(32'h0000_0860, 0, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{service_pass(32'h0000_0D10, 0, 0, 0, 0, 0), 1'b0, '0});
      // Retries exhausted; the packet on the same pass only updates the manual state.
      rows.push_back('{service_pass(32'h0000_11C0, 1, 1, 2, 1, 0), 1'b1,
                       rsp_of(0,0,0,0,1,0,2,0,0,1)});
      rows.push_back('{service_pass(32'h0000_2000, 0, 0, 0, 0, 0), 1'b1,
                       rsp_of(1,crc_pkg::COMMAND_SLEEP,3,0,0,0,0,1,0,0)});
      rows.push_back('{service_pass(32'h0000_2010, 1, 0, 0, 1, 0), 1'b0, '0});
      rows.push_back('{service_pass(32'h0000_2500, 0, 0, 0, 0, 0), 1'b1,
                       rsp_of(0,0,0,0,1,0,3,0,0,0)});
      rows.push_back('{request_of(crc_pkg::COMMAND_MANUAL), 1'b0, '0});
      rows.push_back('{service_pass(32'hFFFF_FFFF, 0, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{service_pass(0, 1, 1, 4, 0, 0), 1'b1, rsp_of(0,0,0,0,0,1,4,0,0,0)});
      rows.push_back('{request_of(crc_pkg::COMMAND_AUTO), 1'b0, '0});
      rows.push_back('{service_pass(5, 0, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{service_pass(6, 1, 0, 0, 0, 0), 1'b0, '0});
      foreach (rows[i]) begin
         send_item(1'b0, rows[i].item, rows[i].has_lit, rows[i].lit);
         sender_gap();
      end
      wait_for_results();

      timeouts = '{1, 65535, 0, 40, 1200};
      retries = '{0, 15, 0, 1, 3};
      timeouts[2] = $urandom_range(1, 65535);
      retries[2] = $urandom_range(0, 15);
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_register(crc_pkg::CSR_ACK_TIMEOUT, DW'(timeouts[p]));
         write_register(crc_pkg::CSR_MAX_RETRIES, DW'(retries[p]));
         clock_ms = $urandom;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            idle_on = (n % 100) < 70;
            if (n == 50) begin
               // Keep offering transfers while the result side is held off.
               hold_off_req = 1'b1;
               while (hold_off_req) send_item(1'b1, '0, 1'b0, '0);
            end
            if (n == 200) wait_for_results();
            send_item(1'b1, '0, 1'b0, '0);
            sender_gap();
         end
         idle_on = 1'b1;
         wait_for_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/crc_pkg.sv
src/crc_ram.sv
src/command_retransmit_controller_top.sv
dv/tb_top.sv
